/* sv/sorted_record_table_macros.svh */
// assertion helpers for the sorted record table
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/srt_pkg.sv */
package srt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    // query read-out: rank is 8 bits and starts at 1, so at most 255 cells are reachable
    localparam int QRY_SPAN    = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int QRY_GRPS    = 16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request codes on the req_type port
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_NOTFOUND,
        ST_RANGE
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVAL,
        BK_APPLY
    } bk_state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [71:0] name;
    } rec_t;

    typedef struct packed {
        op_t        op;
        rec_t       rec;
        logic [7:0] rank;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        status_t    status;
        rec_t       rec;
        logic [7:0] count;
    } res_t;

endpackage

/* sv/sorted_record_table.sv */
// Sorted record table: holds up to TABLE_DEPTH records (signed 32-bit key plus a
// 9-character name) in ascending key order and serves insert, delete-by-key and
// rank-query requests, one result per item. Both sides look like a queue: push
// while full is low, pop while empty is low. An accepted item lands in a
// two-entry command queue; the back end takes it when idle, compares every
// stored key against the item's key in parallel into registered compare
// vectors, then shifts the cell row (or selects the queried record) and
// loads the result register. It works through its take/compare/apply
// sequence one item at a time and takes no new item before it is through
// with the last; a result left unpopped holds the back end in its apply
// step, while the command queue keeps taking items until it fills. Equal
// keys: an insert goes ahead of existing equal keys, a delete removes the
// first one. No clearing pass is needed after reset: only cells below the
// record count are ever looked at.

`include "sorted_record_table_macros.svh"

module sorted_record_table
(
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] key_code,
    input  logic [63:0]        name_head,
    input  logic [7:0]         name_tail,
    input  logic [7:0]         rank,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic signed [31:0] out_code,
    output logic [63:0]        out_name_head,
    output logic [7:0]         out_name_tail,
    output logic [7:0]         entry_count
);

    srt_pkg::q_head_t q_head;
    logic             q_take;
    logic             res_valid;
    srt_pkg::res_t    res;

    // front: classify the request and queue it
    srt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .key_code  (key_code),
        .name_head (name_head),
        .name_tail (name_tail),
        .rank      (rank),
        .q_take    (q_take),
        .q_head    (q_head)
    );

    // back: cell row, compare vectors, result register
    srt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_take    (q_take),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register drives the output side directly
    assign empty         = !res_valid;
    assign status        = res.status;
    assign out_code      = res.rec.key;
    assign out_name_head = res.rec.name[63:0];
    assign out_name_tail = res.rec.name[71:64];
    assign entry_count   = res.count;

    // a full status only when the table really is at capacity
    `SRT_ASSERT_NOW(a_full_at_depth, !empty && status == srt_pkg::ST_FULL, entry_count == 8'(srt_pkg::TABLE_DEPTH), "full status below capacity")

    // any non-ok status carries an all-zero record
    `SRT_ASSERT_NOW(a_err_zero_rec, !empty && status != srt_pkg::ST_OK, out_code == 32'sd0 && out_name_head == 64'd0 && out_name_tail == 8'd0, "error result with record data")

    // a full queue always offers an item to the back end
    `SRT_ASSERT_NOW(a_full_has_head, full, q_head.valid, "queue full without a head item")

    // after an accepted item the queue offers a head item to the back end next cycle
    `SRT_ASSERT_NEXT(a_push_lands, push && !full, q_head.valid, "accepted item lost from queue")

endmodule

/* sv/srt_front.sv */
module srt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        req_type,
    input  logic [31:0]       key_code,
    input  logic [63:0]       name_head,
    input  logic [7:0]        name_tail,
    input  logic [7:0]        rank,
    input  logic              q_take,
    output srt_pkg::q_head_t  q_head
);

    srt_pkg::cmd_t                  fifo_reg [srt_pkg::QUEUE_DEPTH];
    logic [srt_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [srt_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [srt_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [srt_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [srt_pkg::QCNT_W-1:0]     cnt_reg;
    logic [srt_pkg::QCNT_W-1:0]     cnt_next;
    srt_pkg::cmd_t                  cmd_in;
    logic                           wr_en;
    logic                           rd_en;

    // classify the request code
    always_comb
    begin
        cmd_in.rec.key  = key_code;
        cmd_in.rec.name = {name_tail, name_head};
        cmd_in.rank     = rank;
        case (req_type)
            srt_pkg::REQ_INSERT: cmd_in.op = srt_pkg::OP_INSERT;
            srt_pkg::REQ_DELETE: cmd_in.op = srt_pkg::OP_DELETE;
            srt_pkg::REQ_QUERY:  cmd_in.op = srt_pkg::OP_QUERY;
            default:             cmd_in.op = srt_pkg::OP_NOP;
        endcase
    end

    assign full         = (cnt_reg == srt_pkg::QCNT_W'(srt_pkg::QUEUE_DEPTH));
    assign wr_en        = push && !full;
    assign rd_en        = q_take && q_head.valid;
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.cmd   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == srt_pkg::QPTR_W'(srt_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == srt_pkg::QPTR_W'(srt_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + srt_pkg::QCNT_W'(wr_en) - srt_pkg::QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* sv/srt_back.sv */
module srt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  srt_pkg::q_head_t  q_head,
    output logic              q_take,
    input  logic              res_pop,
    output logic              res_valid,
    output srt_pkg::res_t     res
);

    srt_pkg::bk_state_t             state_reg;
    srt_pkg::bk_state_t             state_next;
    srt_pkg::cmd_t                  cmd_reg;
    logic [srt_pkg::CNT_W-1:0]      fill_reg;
    logic [srt_pkg::CNT_W-1:0]      fill_next;
    srt_pkg::rec_t                  cell_reg  [srt_pkg::TABLE_DEPTH];
    srt_pkg::rec_t                  cell_next [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::TABLE_DEPTH-1:0] lt_reg;
    logic [srt_pkg::TABLE_DEPTH-1:0] lt_next;
    logic [srt_pkg::TABLE_DEPTH-1:0] eq_reg;
    logic [srt_pkg::TABLE_DEPTH-1:0] eq_next;
    srt_pkg::rec_t                  cand_reg  [srt_pkg::QRY_GRPS];
    srt_pkg::rec_t                  cand_next [srt_pkg::QRY_GRPS];
    logic [3:0]                     qgrp_reg;
    logic                           rng_bad_reg;
    logic                           rng_bad_next;
    logic [7:0]                     qidx;
    srt_pkg::res_t                  res_reg;
    srt_pkg::res_t                  res_next;
    logic                           res_valid_reg;
    logic                           apply_en;
    logic                           tbl_full;
    logic                           found;

    // sequencer: take, compare, apply
    always_comb
    begin
        state_next = state_reg;
        q_take     = 1'b0;
        apply_en   = 1'b0;
        case (state_reg)
            srt_pkg::BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_take     = 1'b1;
                    state_next = srt_pkg::BK_EVAL;
                end
            end
            srt_pkg::BK_EVAL:
            begin
                state_next = srt_pkg::BK_APPLY;
            end
            srt_pkg::BK_APPLY:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    apply_en   = 1'b1;
                    state_next = srt_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = srt_pkg::BK_IDLE;
            end
        endcase
    end

    // per-cell compare against the command key, plus query pre-select
    assign qidx = cmd_reg.rank - 8'd1;

    always_comb
    begin
        for (int i = 0; i < srt_pkg::TABLE_DEPTH; i++)
        begin
            logic vld;
            vld        = (srt_pkg::CNT_W'(i) < fill_reg);
            lt_next[i] = vld && ($signed(cell_reg[i].key) < $signed(cmd_reg.rec.key));
            eq_next[i] = vld && (cell_reg[i].key == cmd_reg.rec.key);
        end
        for (int g = 0; g < srt_pkg::QRY_GRPS; g++)
        begin
            cand_next[g] = '0;
        end
        for (int i = 0; i < srt_pkg::QRY_SPAN; i++)
        begin
            logic [7:0] iv;
            iv = 8'(i);
            if (iv[3:0] == qidx[3:0])
            begin
                cand_next[iv[7:4]] = cell_reg[i];
            end
        end
        rng_bad_next = (cmd_reg.rank == 8'd0)
                    || (srt_pkg::CMP_W'(cmd_reg.rank) > srt_pkg::CMP_W'(fill_reg));
    end

    // table update and result
    assign tbl_full = (fill_reg == srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH));
    assign found    = |eq_reg;

    always_comb
    begin
        for (int i = 0; i < srt_pkg::TABLE_DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        fill_next      = fill_reg;
        res_next       = '0;
        res_next.status = srt_pkg::ST_OK;
        case (cmd_reg.op)
            srt_pkg::OP_INSERT:
            begin
                if (tbl_full)
                begin
                    res_next.status = srt_pkg::ST_FULL;
                end
                else
                begin
                    // cells at or past the slot move up one
                    if (!lt_reg[0])
                    begin
                        cell_next[0] = cmd_reg.rec;
                    end
                    for (int i = 1; i < srt_pkg::TABLE_DEPTH; i++)
                    begin
                        if (!lt_reg[i])
                        begin
                            cell_next[i] = lt_reg[i-1] ? cmd_reg.rec : cell_reg[i-1];
                        end
                    end
                    fill_next = fill_reg + 1'b1;
                end
            end
            srt_pkg::OP_DELETE:
            begin
                if (!found)
                begin
                    res_next.status = srt_pkg::ST_NOTFOUND;
                end
                else
                begin
                    // first match starts the run of keys not below it
                    for (int i = 0; i < srt_pkg::TABLE_DEPTH - 1; i++)
                    begin
                        if (!lt_reg[i])
                        begin
                            cell_next[i] = cell_reg[i+1];
                        end
                    end
                    fill_next = fill_reg - 1'b1;
                end
            end
            srt_pkg::OP_QUERY:
            begin
                if (rng_bad_reg)
                begin
                    res_next.status = srt_pkg::ST_RANGE;
                end
                else
                begin
                    res_next.rec = cand_reg[qgrp_reg];
                end
            end
            default:
            begin
                res_next.status = srt_pkg::ST_OK;
            end
        endcase
        res_next.count = 8'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srt_pkg::BK_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_en)
            begin
                fill_reg <= fill_next;
            end
            res_valid_reg <= apply_en || (res_valid_reg && !res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cmd_reg <= q_head.cmd;
        end
        if (state_reg == srt_pkg::BK_EVAL)
        begin
            lt_reg      <= lt_next;
            eq_reg      <= eq_next;
            cand_reg    <= cand_next;
            qgrp_reg    <= qidx[7:4];
            rng_bad_reg <= rng_bad_next;
        end
        if (apply_en)
        begin
            cell_reg <= cell_next;
            res_reg  <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
